// ----- src/bitmap_page_frame_allocator_macros.svh -----
// Assertion macros for the bitmap page frame allocator checker.
// No dependencies; included by files that carry assertions.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// Property holds on every clock edge outside reset.
`define BPFA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bpfa assertion failed");

// Consequent holds in the cycle after the antecedent.
`define BPFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bpfa assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define BPFA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bpfa assertion failed");

`endif

// ----- src/bpfa_pkg.sv -----
// Shared constants, types and helpers of the bitmap page frame allocator.
// No dependencies.
`timescale 1ns / 1ps
package bpfa_pkg;

  localparam int unsigned FRAMES     = 4096;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PFN_W      = ADDR_W - PAGE_SHIFT;
  localparam int unsigned FRAME_W    = $clog2(FRAMES);
  localparam int unsigned CNT_W      = $clog2(FRAMES + 1);
  localparam int unsigned ROW_BITS   = 64;
  localparam int unsigned BIT_W      = $clog2(ROW_BITS);
  localparam int unsigned ROWS       = (FRAMES + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ROW_W      = $clog2(ROWS);
  localparam int unsigned PAGE_MASK  = (1 << PAGE_SHIFT) - 1;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH = CFG_IDX_W'(1);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic alloc_rd;
    logic alloc_hit;
    logic alloc_next;
    logic alloc_oom;
    logic free_rd;
    logic free_ok;
    logic free_bad;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cand_ok;
    logic hit;
    logic at_last_row;
    logic free_idx_bad;
    logic free_bit_set;
  } dp_stat_t;

  function automatic logic [ROW_W-1:0] ffs_rows(input logic [ROWS-1:0] v);
    logic [ROW_W-1:0] idx;
    idx = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (v[i]) idx = ROW_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [BIT_W-1:0] ffs_bits(input logic [ROW_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

// ----- src/bpfa_ctrl.sv -----
// Sequencer of the bitmap page frame allocator.
// Depends on bpfa_pkg for the command and status structs.
`timescale 1ns / 1ps
module bpfa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               mode_i,
  input  bpfa_pkg::dp_stat_t stat_i,
  output bpfa_pkg::ctrl_cmd_t cmd_o,
  output logic               busy_o
);
  import bpfa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_FIND,
    S_ALLOC_CHECK,
    S_FREE_READ,
    S_FREE_CHECK
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = (mode_i == MODE_FREE) ? S_FREE_READ : S_ALLOC_FIND;
        end
      end
      S_ALLOC_FIND: begin
        if (stat_i.cand_ok) begin
          cmd_o.alloc_rd = 1'b1;
          state_d        = S_ALLOC_CHECK;
        end else begin
          cmd_o.alloc_oom = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_ALLOC_CHECK: begin
        priority if (stat_i.hit) begin
          cmd_o.alloc_hit = 1'b1;
          state_d         = S_IDLE;
        end else if (stat_i.at_last_row) begin
          cmd_o.alloc_oom = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.alloc_next = 1'b1;
          state_d          = S_ALLOC_FIND;
        end
      end
      S_FREE_READ: begin
        if (stat_i.free_idx_bad) begin
          cmd_o.free_bad = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.free_rd = 1'b1;
          state_d       = S_FREE_CHECK;
        end
      end
      S_FREE_CHECK: begin
        if (stat_i.free_bit_set) cmd_o.free_ok = 1'b1;
        else cmd_o.free_bad = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- src/bpfa_datapath.sv -----
// Datapath of the bitmap page frame allocator: range registers, used map,
// row summary bits, count and result registers. Depends on bpfa_pkg.
`timescale 1ns / 1ps
module bpfa_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]  cfg_wdata_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]  free_address_i,
  input  bpfa_pkg::ctrl_cmd_t          cmd_i,
  output bpfa_pkg::dp_stat_t           stat_o,
  output logic                         done_o,
  output logic [bpfa_pkg::ADDR_W-1:0]  frame_address_o,
  output logic [1:0]                   status_o,
  output logic [bpfa_pkg::CNT_W-1:0]   allocated_count_o
);
  import bpfa_pkg::*;

  logic [ADDR_W-1:0]   low_q, high_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [FRAME_W-1:0]  first_q;
  logic [ROW_W-1:0]    last_row_q;
  logic [BIT_W-1:0]    last_bit_q;
  logic                empty_q;
  logic [ROW_W-1:0]    ptr_q;
  logic [ROW_W-1:0]    row_q;
  logic [ROWS-1:0]     full_q;
  logic [ROWS-1:0]     row_valid_q;
  logic [CNT_W-1:0]    count_q;
  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROW_BITS-1:0] rd_data_q;
  logic                res_valid_q;
  logic [ADDR_W-1:0]   res_addr_q;
  status_e             res_status_q;

  // Range decode at accept
  logic [ADDR_W:0]     first_sum;
  logic [PFN_W:0]      first_fr;
  logic [PFN_W-1:0]    end_fr;
  logic [CNT_W-1:0]    end_c;
  logic [CNT_W-1:0]    last_idx;
  logic                empty_d;

  always_comb begin
    first_sum = {1'b0, low_q} + (ADDR_W + 1)'(PAGE_MASK);
    first_fr  = first_sum[ADDR_W:PAGE_SHIFT];
    end_fr    = high_q[ADDR_W-1:PAGE_SHIFT];
    end_c     = (end_fr > PFN_W'(FRAMES)) ? CNT_W'(FRAMES) : end_fr[CNT_W-1:0];
    empty_d   = (first_fr >= (PFN_W + 1)'(end_c));
    last_idx  = end_c - CNT_W'(1);
  end

  // Candidate row search over the summary bits
  logic [ROWS-1:0]  cand_vec;
  logic [ROW_W-1:0] cand_row;

  always_comb begin
    cand_vec = ~full_q & ({ROWS{1'b1}} << ptr_q);
    cand_row = ffs_rows(cand_vec);
  end

  // Row check
  logic [ROW_BITS-1:0] rd_eff, lo_mask, hi_mask, free_bits, new_row;
  logic [BIT_W-1:0]    hit_bit;
  logic [PFN_W-1:0]    free_pfn;
  logic [ROW_W-1:0]    free_row;
  logic [BIT_W-1:0]    free_bit;

  always_comb begin
    rd_eff    = row_valid_q[row_q] ? rd_data_q : '0;
    lo_mask   = (row_q == first_q[FRAME_W-1 -: ROW_W])
              ? ({ROW_BITS{1'b1}} << first_q[BIT_W-1:0]) : {ROW_BITS{1'b1}};
    hi_mask   = (row_q == last_row_q)
              ? ({ROW_BITS{1'b1}} >> (BIT_W'(ROW_BITS - 1) - last_bit_q))
              : {ROW_BITS{1'b1}};
    free_bits = ~rd_eff & lo_mask & hi_mask;
    hit_bit   = ffs_bits(free_bits);
    new_row   = rd_eff | (ROW_BITS'(1) << hit_bit);
    free_pfn  = addr_q[ADDR_W-1:PAGE_SHIFT];
    free_row  = free_pfn[FRAME_W-1 -: ROW_W];
    free_bit  = free_pfn[BIT_W-1:0];
  end

  always_comb begin
    stat_o.cand_ok      = !empty_q && (|cand_vec) && (cand_row <= last_row_q);
    stat_o.hit          = |free_bits;
    stat_o.at_last_row  = (row_q == last_row_q);
    stat_o.free_idx_bad = (free_pfn >= PFN_W'(FRAMES));
    stat_o.free_bit_set = rd_eff[free_bit];
  end

  // Used map memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_rd) rd_data_q <= mem[cand_row];
    else if (cmd_i.free_rd) rd_data_q <= mem[free_row];
    if (cmd_i.alloc_hit) mem[row_q] <= new_row;
    else if (cmd_i.free_ok) mem[row_q] <= rd_eff & ~(ROW_BITS'(1) << free_bit);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q     <= free_address_i;
      first_q    <= first_fr[FRAME_W-1:0];
      last_row_q <= last_idx[FRAME_W-1 -: ROW_W];
      last_bit_q <= last_idx[BIT_W-1:0];
    end
    if (cmd_i.alloc_rd) row_q <= cand_row;
    else if (cmd_i.free_rd) row_q <= free_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q        <= '0;
      high_q       <= '0;
      empty_q      <= 1'b1;
      ptr_q        <= '0;
      full_q       <= '0;
      row_valid_q  <= '0;
      count_q      <= '0;
      res_valid_q  <= 1'b0;
      res_addr_q   <= '0;
      res_status_q <= ST_OK;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_LOW:  low_q  <= cfg_wdata_i;
          CFG_HIGH: high_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        empty_q <= empty_d;
        ptr_q   <= first_fr[FRAME_W-1 -: ROW_W];
      end
      if (cmd_i.alloc_next) ptr_q <= row_q + ROW_W'(1);
      if (cmd_i.alloc_hit) begin
        full_q[row_q]      <= &new_row;
        row_valid_q[row_q] <= 1'b1;
        count_q            <= count_q + CNT_W'(1);
      end
      if (cmd_i.free_ok) begin
        full_q[row_q] <= 1'b0;
        count_q       <= count_q - CNT_W'(1);
      end
      res_valid_q <= cmd_i.alloc_hit | cmd_i.alloc_oom | cmd_i.free_ok | cmd_i.free_bad;
      res_addr_q  <= cmd_i.alloc_hit
                   ? {{(PFN_W - FRAME_W){1'b0}}, row_q, hit_bit, {PAGE_SHIFT{1'b0}}}
                   : '0;
      priority if (cmd_i.alloc_oom) res_status_q <= ST_OOM;
      else if (cmd_i.free_bad) res_status_q <= ST_BAD_FREE;
      else res_status_q <= ST_OK;
    end
  end

  assign done_o            = res_valid_q;
  assign frame_address_o   = res_addr_q;
  assign status_o          = res_status_q;
  assign allocated_count_o = count_q;

endmodule

// ----- src/bitmap_page_frame_allocator.sv -----
// Top level of the bitmap page frame allocator: sequencer plus datapath.
// Depends on bpfa_pkg, bpfa_ctrl and bpfa_datapath.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  request  | start_i / busy_o      | mode_i, free_address_i
//  result   | done_o (1-cycle)      | frame_address_o, status_o,
//           |                       | allocated_count_o
//  config   | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// Allocate reads and checks a candidate row, going on after a miss, and ends
// at once with no candidate row; free checks its bit unless out of range.
// The map is 64-bit rows in a memory; a row summary vector picks the next
// row with a free frame, so each row read is one registered memory access.
// Reset clears the row valid and summary bits at once; no clearing pass.
// Results cannot be stalled; a new item is taken while the strobe is up.
`timescale 1ns / 1ps
module bitmap_page_frame_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]    cfg_wdata_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           mode_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]    free_address_i,
  output logic                           done_o,
  output logic [bpfa_pkg::ADDR_W-1:0]    frame_address_o,
  output logic [1:0]                     status_o,
  output logic [bpfa_pkg::CNT_W-1:0]     allocated_count_o
);
  import bpfa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  bpfa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (mode_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  bpfa_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .free_address_i    (free_address_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .done_o            (done_o),
    .frame_address_o   (frame_address_o),
    .status_o          (status_o),
    .allocated_count_o (allocated_count_o)
  );

endmodule

// ----- src/bpfa_checker.sv -----
// Port-level checker of the bitmap page frame allocator, bound to the top.
// Depends on bpfa_pkg and bitmap_page_frame_allocator_macros.svh.
`timescale 1ns / 1ps
`include "bitmap_page_frame_allocator_macros.svh"
module bpfa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [bpfa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [bpfa_pkg::ADDR_W-1:0]    cfg_wdata_i,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           mode_i,
  input logic [bpfa_pkg::ADDR_W-1:0]    free_address_i,
  input logic                           done_o,
  input logic [bpfa_pkg::ADDR_W-1:0]    frame_address_o,
  input logic [1:0]                     status_o,
  input logic [bpfa_pkg::CNT_W-1:0]     allocated_count_o
);
  import bpfa_pkg::*;

  `BPFA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `BPFA_ASSERT_SAME(a_done_idle, clk_i, rst_ni, done_o, !busy_o)
  `BPFA_ASSERT_SAME(a_fail_zero_addr, clk_i, rst_ni, done_o && (status_o != ST_OK), frame_address_o == '0)
  `BPFA_ASSERT_SAME(a_count_range, clk_i, rst_ni, done_o, allocated_count_o <= CNT_W'(FRAMES))

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (.*);
